/* hdl/priority_failover_selector_defines.svh */
// assertion macros used by the selector's checker file
`ifndef PRIORITY_FAILOVER_SELECTOR_DEFINES_SVH
`define PRIORITY_FAILOVER_SELECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfs_pkg.sv */
// types, constants and codes of the priority failover selector
`default_nettype none

package pfs_pkg;

  // fixed field widths
  localparam int NODE_W     = 3;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 32;
  localparam int TIME_W     = 64;
  localparam int COUNT_W    = 4;
  localparam int LANE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // parameter defaults
  localparam int NODES_DEF     = 8;
  localparam int PRIO_BITS_DEF = 8;

  // configuration reset values
  localparam logic [COUNT_W-1:0]    NODES_IN_USE_RST = 4'd1;
  localparam logic [CNT_W-1:0]      COOLDOWN_RST     = 32'd30000;
  localparam logic [LANE_W-1:0]     ENABLE_RST       = 8'hff;
  localparam logic [TIME_W-1:0]     PRIORITY_RST     = 64'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODES_IN_USE  = 3'd0,
    CFG_COOLDOWN      = 3'd1,
    CFG_PREFER_HIGHER = 3'd2,
    CFG_ENABLE_MASK   = 3'd3,
    CFG_PRIORITY      = 3'd4
  } cfg_reg_t;

  // function codes of an input word
  typedef enum logic [FUNC_W-1:0] {
    FN_MARK_FAILED  = 3'd0,
    FN_MARK_SUCCESS = 3'd1,
    FN_NEXT_NODE    = 3'd2,
    FN_TRY_HIGHER   = 3'd3,
    FN_NODE_STATUS  = 3'd4
  } func_t;

  // node status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DISABLED = 3'd0,
    ST_ACTIVE   = 3'd1,
    ST_COOLING  = 3'd2,
    ST_READY    = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WORK = 1'b1
  } state_t;

  // one node's health record
  typedef struct packed {
    logic [TIME_W-1:0] fail_time;
    logic [TIME_W-1:0] ok_time;
    logic [CNT_W-1:0]  streak;
    logic [CNT_W-1:0]  ok_cnt;
    logic [CNT_W-1:0]  fail_cnt;
  } node_entry_t;

  // write request into the health table
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    node_entry_t       entry;
  } table_wr_t;

endpackage

`default_nettype wire

/* hdl/pfs_node_table.sv */
// per-node health table: one read port, one write port, cleared by valid bits
`default_nettype none

module pfs_node_table #(
  parameter int NODES = pfs_pkg::NODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [pfs_pkg::NODE_W-1:0] rd_node,
  output pfs_pkg::node_entry_t           rd_entry,
  input  wire pfs_pkg::table_wr_t        wr
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  pfs_pkg::node_entry_t mem [NODES];
  logic [NODES-1:0]     valid;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_idx = rd_node[IDX_W-1:0];
  assign wr_idx = wr.node[IDX_W-1:0];

  // entries never written read as zero
  assign rd_entry = valid[rd_idx] ? mem[rd_idx] : '0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.entry;
    end
  end

endmodule

`default_nettype wire

/* hdl/priority_failover_selector.sv */
// Priority failover selector: node health table and failover choice.
//
// Input channel (in_valid/in_ready) carries one word: func, node_sel,
// active_node, now_ms. Output channel (out_valid/out_ready) returns exactly
// one result word per input word. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must write it only while the block
// is idle, which the block itself does not enforce.
// Sequencing: a mark, status or unused function completes without a scan;
// next-node and try-higher scan all NODES table entries with the single
// cooldown compare unit, which visits one table entry per cycle, save that
// the last step waits while the output register holds an untaken result.
// The result is registered at the edge that ends the last step, and in_ready
// rises at that same edge, so a new word may enter while the result waits.
//
// Reset (rst, synchronous) restores the configuration defaults and clears
// every health record through per-node valid bits; no clearing sweep.
// When out_ready is held low the finished result holds in the output
// register and the next word stalls on its last step until it is taken.
`default_nettype none

module priority_failover_selector #(
  parameter int NODES     = pfs_pkg::NODES_DEF,
  parameter int PRIO_BITS = pfs_pkg::PRIO_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pfs_pkg::FUNC_W-1:0]      func,
  input  wire logic [pfs_pkg::NODE_W-1:0]      node_sel,
  input  wire logic [pfs_pkg::NODE_W-1:0]      active_node,
  input  wire logic [pfs_pkg::TIME_W-1:0]      now_ms,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 found,
  output logic [pfs_pkg::NODE_W-1:0]           chosen_node,
  output logic                                 higher_usable,
  output logic [pfs_pkg::STATUS_W-1:0]         node_status,
  output logic [pfs_pkg::CNT_W-1:0]            fail_streak,
  output logic [pfs_pkg::CNT_W-1:0]            success_total,
  output logic [pfs_pkg::CNT_W-1:0]            failure_total,
  output logic [pfs_pkg::TIME_W-1:0]           success_stamp,
  output logic [pfs_pkg::TIME_W-1:0]           failure_stamp
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
  localparam logic [pfs_pkg::COUNT_W-1:0] NODES_CNT = pfs_pkg::COUNT_W'(NODES);

  // configuration registers
  logic [pfs_pkg::COUNT_W-1:0] nodes_in_use;
  logic [pfs_pkg::CNT_W-1:0]   cooldown_len;
  logic                        prefer_higher;
  logic [pfs_pkg::LANE_W-1:0]  enable_mask;
  logic [pfs_pkg::TIME_W-1:0]  priority_words;

  // captured input word
  pfs_pkg::func_t              func_q;
  logic [pfs_pkg::NODE_W-1:0]  sel_q;
  logic [pfs_pkg::NODE_W-1:0]  act_q;
  logic [pfs_pkg::TIME_W-1:0]  now_q;

  // sequencer
  pfs_pkg::state_t state;
  pfs_pkg::state_t state_next;
  logic [IDX_W-1:0] idx;

  // scan accumulators
  logic                 have_best, have_best_next;
  logic                 have_fb, have_fb_next;
  logic [IDX_W-1:0]     best, best_next;
  logic [IDX_W-1:0]     fb, fb_next;
  logic [PRIO_BITS-1:0] best_p, best_p_next;
  logic [PRIO_BITS-1:0] fb_p, fb_p_next;
  logic                 hit, hit_next;

  // step control
  logic accept;
  logic is_scan;
  logic last;
  logic out_free;
  logic adv;
  logic finish;

  // table access
  logic [pfs_pkg::NODE_W-1:0] rd_node;
  logic [pfs_pkg::NODE_W-1:0] scan_node;
  pfs_pkg::node_entry_t       ent;
  pfs_pkg::node_entry_t       upd;
  pfs_pkg::table_wr_t         wr;

  // shared cooldown compare and node qualifiers
  logic [pfs_pkg::COUNT_W-1:0] count;
  logic [pfs_pkg::TIME_W-1:0]  elapsed;
  logic                        cooling;
  logic                        scan_present;
  logic                        sel_present;
  logic [PRIO_BITS-1:0]        cur_prio;
  logic [PRIO_BITS-1:0]        scan_prio;
  logic                        cand;
  pfs_pkg::status_t            status_val;

  pfs_node_table #(
    .NODES (NODES)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_node  (rd_node),
    .rd_entry (ent),
    .wr       (wr)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use   <= pfs_pkg::NODES_IN_USE_RST;
      cooldown_len   <= pfs_pkg::COOLDOWN_RST;
      prefer_higher  <= 1'b0;
      enable_mask    <= pfs_pkg::ENABLE_RST;
      priority_words <= pfs_pkg::PRIORITY_RST;
    end else if (cfg_we) begin
      case (pfs_pkg::cfg_reg_t'(cfg_index))
        pfs_pkg::CFG_NODES_IN_USE:  nodes_in_use   <= cfg_data[pfs_pkg::COUNT_W-1:0];
        pfs_pkg::CFG_COOLDOWN:      cooldown_len   <= cfg_data[pfs_pkg::CNT_W-1:0];
        pfs_pkg::CFG_PREFER_HIGHER: prefer_higher  <= cfg_data[0];
        pfs_pkg::CFG_ENABLE_MASK:   enable_mask    <= cfg_data[pfs_pkg::LANE_W-1:0];
        pfs_pkg::CFG_PRIORITY:      priority_words <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and step control
  assign accept   = in_valid && in_ready;
  assign is_scan  = (func_q == pfs_pkg::FN_NEXT_NODE) || (func_q == pfs_pkg::FN_TRY_HIGHER);
  assign last     = is_scan ? (idx == LAST_IDX) : 1'b1;
  assign out_free = !out_valid || out_ready;
  assign adv      = (state == pfs_pkg::S_WORK) && (!last || out_free);
  assign finish   = adv && last;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfs_pkg::S_IDLE: begin
        if (in_valid) state_next = pfs_pkg::S_WORK;
      end
      pfs_pkg::S_WORK: begin
        if (finish) state_next = pfs_pkg::S_IDLE;
      end
      default: state_next = pfs_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state)
      pfs_pkg::S_IDLE: in_ready = 1'b1;
      default:         in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (adv && !last) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= pfs_pkg::func_t'(func);
      sel_q  <= node_sel;
      act_q  <= active_node;
      now_q  <= now_ms;
    end
  end

  // node count, clamped to the table size
  assign count = (nodes_in_use > NODES_CNT) ? NODES_CNT : nodes_in_use;

  // table read address: scan position or selected node
  assign scan_node = pfs_pkg::NODE_W'(idx);
  assign rd_node   = is_scan ? scan_node : sel_q;

  // shared cooldown unit
  assign elapsed = now_q - ent.fail_time;
  assign cooling = (ent.streak != '0) &&
                   (elapsed < {{(pfs_pkg::TIME_W - pfs_pkg::CNT_W){1'b0}}, cooldown_len});

  // node qualifiers
  assign scan_present = {1'b0, scan_node} < count;
  assign sel_present  = {1'b0, sel_q} < count;
  assign cur_prio     = priority_words[{sel_q, 3'b000} +: PRIO_BITS];
  assign scan_prio    = priority_words[{scan_node, 3'b000} +: PRIO_BITS];
  assign cand         = scan_present && (scan_node != sel_q) && enable_mask[scan_node] &&
                        (scan_prio > cur_prio);

  // accumulator update for this step
  always_comb begin
    have_best_next = have_best;
    best_next      = best;
    best_p_next    = best_p;
    have_fb_next   = have_fb;
    fb_next        = fb;
    fb_p_next      = fb_p;
    hit_next       = hit;
    if (func_q == pfs_pkg::FN_NEXT_NODE && cand) begin
      if (cooling) begin
        if (!have_fb || scan_prio < fb_p) begin
          have_fb_next = 1'b1;
          fb_next      = idx;
          fb_p_next    = scan_prio;
        end
      end else if (!have_best || scan_prio < best_p) begin
        have_best_next = 1'b1;
        best_next      = idx;
        best_p_next    = scan_prio;
      end
    end
    if (func_q == pfs_pkg::FN_TRY_HIGHER && prefer_higher && (act_q != '0) &&
        (scan_node < act_q) && scan_present && enable_mask[scan_node] && !cooling) begin
      hit_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || accept) begin
      have_best <= 1'b0;
      have_fb   <= 1'b0;
      hit       <= 1'b0;
    end else if (adv) begin
      have_best <= have_best_next;
      have_fb   <= have_fb_next;
      hit       <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      best   <= best_next;
      best_p <= best_p_next;
      fb     <= fb_next;
      fb_p   <= fb_p_next;
    end
  end

  // record update for marks
  always_comb begin
    upd = ent;
    if (func_q == pfs_pkg::FN_MARK_FAILED) begin
      upd.fail_time = now_q;
      upd.streak    = ent.streak + pfs_pkg::CNT_W'(1);
      upd.fail_cnt  = ent.fail_cnt + pfs_pkg::CNT_W'(1);
    end else begin
      upd.ok_time = now_q;
      upd.streak  = '0;
      upd.ok_cnt  = ent.ok_cnt + pfs_pkg::CNT_W'(1);
    end
    wr.en    = finish && sel_present &&
               (func_q == pfs_pkg::FN_MARK_FAILED || func_q == pfs_pkg::FN_MARK_SUCCESS);
    wr.node  = sel_q;
    wr.entry = upd;
  end

  // status of the selected node
  always_comb begin
    if (!sel_present) begin
      status_val = pfs_pkg::ST_INVALID;
    end else if (!enable_mask[sel_q]) begin
      status_val = pfs_pkg::ST_DISABLED;
    end else if (sel_q == act_q) begin
      status_val = pfs_pkg::ST_ACTIVE;
    end else if (cooling) begin
      status_val = pfs_pkg::ST_COOLING;
    end else begin
      status_val = pfs_pkg::ST_READY;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (finish) begin
      found         <= 1'b0;
      chosen_node   <= '0;
      higher_usable <= 1'b0;
      node_status   <= pfs_pkg::ST_DISABLED;
      fail_streak   <= '0;
      success_total <= '0;
      failure_total <= '0;
      success_stamp <= '0;
      failure_stamp <= '0;
      case (func_q)
        pfs_pkg::FN_NEXT_NODE: begin
          if (have_best_next) begin
            found       <= 1'b1;
            chosen_node <= pfs_pkg::NODE_W'(best_next);
          end else if (have_fb_next) begin
            found       <= 1'b1;
            chosen_node <= pfs_pkg::NODE_W'(fb_next);
          end
        end
        pfs_pkg::FN_TRY_HIGHER: begin
          higher_usable <= hit_next;
        end
        pfs_pkg::FN_NODE_STATUS: begin
          node_status <= status_val;
          if (sel_present) begin
            fail_streak   <= ent.streak;
            success_total <= ent.ok_cnt;
            failure_total <= ent.fail_cnt;
            success_stamp <= ent.ok_time;
            failure_stamp <= ent.fail_time;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pfs_checker.sv */
// port-level checks of the priority failover selector, bound to the top level
`default_nettype none

`include "priority_failover_selector_defines.svh"

module pfs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          found,
  input wire logic [pfs_pkg::NODE_W-1:0]    chosen_node,
  input wire logic [pfs_pkg::STATUS_W-1:0]  node_status,
  input wire logic [pfs_pkg::CNT_W-1:0]     fail_streak,
  input wire logic [pfs_pkg::CNT_W-1:0]     success_total
);

  // one word at a time: ready drops right after an accept
  `PFS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")

  // a stalled result word holds
  `PFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(chosen_node) && $stable(node_status), "stalled result changed")

  // no search hit means node index zero
  `PFS_ASSERT_NOW(a_none_zero, out_valid && !found, chosen_node == '0, "chosen_node nonzero without a hit")

  // an absent node reports no counters
  `PFS_ASSERT_NOW(a_invalid_zero, out_valid && node_status == pfs_pkg::ST_INVALID, fail_streak == '0 && success_total == '0, "counters reported for absent node")

endmodule

bind priority_failover_selector pfs_checker u_pfs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .found         (found),
  .chosen_node   (chosen_node),
  .node_status   (node_status),
  .fail_streak   (fail_streak),
  .success_total (success_total)
);

`default_nettype wire
